// File: rtl/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CAP_W         = 5;
    localparam int CNT_OUT_W     = 5;
    localparam int OPCODE_W      = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_GET   = 2'd0,
        OP_PEEK  = 2'd1,
        OP_PUT   = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    // Update strobes broadcast to every cell of the row
    typedef struct packed {
        logic look;        // register the key compare
        logic shift_all;   // every cell takes its neighbor's entry
        logic shift_tail;  // cells at or above the hit take their neighbor's entry
        logic set_valid;   // reload valid from the new entry count
        logic clear;       // drop every entry
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lru_key_value_cache_top.sv
`default_nettype none

// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: opcode; tdata: key, write_value
// m_axis    out  m_axis_tvalid / m_axis_tready   tuser: hit, evicted; tdata: read_value,
//                                                entry_count
// cfg       in   cfg_valid / cfg_ready           cfg_data: capacity
//
// Each word is handled in order: accept, key compare in every cell, then the row
// shifts and the result is registered. The next word is taken once the row update
// is done. The apply step waits while an earlier result is still held on m_axis.
// Reset empties the row at once (valid bits clear) and loads capacity 16.

module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int IN_W      = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((VALUE_BITS + CNT_OUT_W + 7) / 8) * 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [IN_W-1:0]     s_axis_tdata,   // key, write_value
    input  wire logic [OPCODE_W-1:0] s_axis_tuser,   // opcode

    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [OUT_W-1:0]    m_axis_tdata,   // read_value, entry_count
    output logic      [1:0]          m_axis_tuser,   // hit, evicted

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CAP_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_APPLY
    } state_t;

    state_t                  state_reg;
    opcode_t                 op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   wval_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CAP_W-1:0]        capacity_reg;

    logic                    out_valid_reg;
    logic [VALUE_BITS-1:0]   out_value_reg, out_value_next;
    logic [CNT_OUT_W-1:0]    out_count_reg;
    logic                    out_hit_reg, out_hit_next;
    logic                    out_evict_reg, out_evict_next;

    cell_ctrl_t              ctrl;
    logic                    apply;
    logic                    hit;
    logic [VALUE_BITS-1:0]   hit_value;
    logic [KEY_BITS-1:0]     head_key;
    logic [VALUE_BITS-1:0]   head_value;

    logic [CMP_W-1:0]        eff_cap, grown;

    logic [KEY_BITS-1:0]     key_link   [0:DEPTH];
    logic [VALUE_BITS-1:0]   value_link [0:DEPTH];
    logic                    tail_link  [0:DEPTH];
    logic [VALUE_BITS-1:0]   sel_link   [0:DEPTH];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {out_evict_reg, out_hit_reg};

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[VALUE_BITS-1:0]            = out_value_reg;
        m_axis_tdata[VALUE_BITS +: CNT_OUT_W]   = out_count_reg;
    end

    assign apply = (state_reg == ST_APPLY) && (!out_valid_reg || m_axis_tready);

    // Hit position and its value come back up the row to cell 0
    assign tail_link[DEPTH] = 1'b0;
    assign sel_link[DEPTH]  = '0;
    assign hit              = tail_link[0];
    assign hit_value        = sel_link[0];

    assign head_key   = key_reg;
    assign head_value = (op_reg == OP_PUT) ? wval_reg : hit_value;
    assign key_link[0]   = head_key;
    assign value_link[0] = head_value;

    assign eff_cap = (CMP_W'(capacity_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                            : CMP_W'(capacity_reg);
    assign grown   = CMP_W'(count_reg) + CMP_W'(1);

    always_comb
    begin
        ctrl           = '0;
        ctrl.look      = (state_reg == ST_LOOK);
        count_next     = count_reg;
        out_hit_next   = 1'b0;
        out_value_next = '0;
        out_evict_next = 1'b0;
        if (apply)
        begin
            unique case (op_reg)
                OP_GET:
                begin
                    out_hit_next    = hit;
                    out_value_next  = hit ? hit_value : '0;
                    ctrl.shift_tail = hit;
                end
                OP_PEEK:
                begin
                    out_hit_next   = hit;
                    out_value_next = hit ? hit_value : '0;
                end
                OP_PUT:
                begin
                    out_hit_next = hit;
                    if (hit)
                    begin
                        ctrl.shift_tail = 1'b1;
                    end
                    else
                    begin
                        ctrl.shift_all = 1'b1;
                        ctrl.set_valid = 1'b1;
                        if (grown > eff_cap)
                        begin
                            out_evict_next = 1'b1;
                        end
                        else
                        begin
                            count_next = grown[CNT_W-1:0];
                        end
                    end
                end
                OP_CLEAR:
                begin
                    ctrl.clear = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    ctrl.clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg   <= opcode_t'(s_axis_tuser);
            key_reg  <= s_axis_tdata[KEY_BITS-1:0];
            wval_reg <= s_axis_tdata[KEY_BITS +: VALUE_BITS];
        end
        if (apply)
        begin
            out_value_reg <= out_value_next;
            out_count_reg <= CNT_OUT_W'(count_next);
            out_hit_reg   <= out_hit_next;
            out_evict_reg <= out_evict_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            capacity_reg  <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (apply)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    if (apply)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        lkvc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .req_key    (key_reg),
            .new_count  (count_next),
            .prev_key   (key_link[i]),
            .prev_value (value_link[i]),
            .key_out    (key_link[i+1]),
            .value_out  (value_link[i+1]),
            .tail_in    (tail_link[i+1]),
            .tail_out   (tail_link[i]),
            .sel_in     (sel_link[i+1]),
            .sel_out    (sel_link[i])
        );
    end

endmodule

`default_nettype wire

// File: rtl/lkvc_cell.sv
`default_nettype none

module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [KEY_BITS-1:0]   req_key,
    input  wire logic [CNT_W-1:0]      new_count,
    input  wire logic [KEY_BITS-1:0]   prev_key,
    input  wire logic [VALUE_BITS-1:0] prev_value,
    output logic      [KEY_BITS-1:0]   key_out,
    output logic      [VALUE_BITS-1:0] value_out,
    input  wire logic                  tail_in,
    output logic                       tail_out,
    input  wire logic [VALUE_BITS-1:0] sel_in,
    output logic      [VALUE_BITS-1:0] sel_out
);

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  valid_reg;
    logic                  match_reg;
    logic                  take;

    assign key_out   = key_reg;
    assign value_out = value_reg;

    // tail_out: a match sits in this cell or in one further down the row
    assign tail_out = tail_in | match_reg;
    assign sel_out  = sel_in | (match_reg ? value_reg : '0);
    assign take     = ctrl.shift_all | (ctrl.shift_tail & tail_out);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.look)
            begin
                match_reg <= valid_reg && (key_reg == req_key);
            end
            if (ctrl.clear)
            begin
                valid_reg <= 1'b0;
            end
            else if (ctrl.set_valid)
            begin
                valid_reg <= (CNT_W'(IDX) < new_count);
            end
        end
    end

endmodule

`default_nettype wire
